/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the positional list engine.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ple_pkg.sv */
// Package of the positional list engine: request codes, status codes, widths.
// No dependencies.
package ple_pkg;

   localparam int DATA_W   = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_INSERT     = 3'd2,
      ACT_REMOVE_AT  = 3'd3,
      ACT_POP_FRONT  = 3'd4,
      ACT_POP_BACK   = 3'd5,
      ACT_READ       = 3'd6,
      ACT_CLEAR      = 3'd7
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

endpackage

/* rtl/core/ple_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/positional_list_engine.sv */
// Positional list engine top level: request sequencer over a value RAM and a link RAM.
// Depends on ple_pkg, ple_ram and assert_macros.svh.
//
// Usage:
//   A request (req_action, req_value, req_position) is taken at a rising edge with
//   start high and busy low. Every request gives exactly one result: rsp_strobe is
//   high for one cycle with rsp_read_value, rsp_count and rsp_status.
//   Refused requests (full, empty, position out of range) and clear answer with the
//   strobe in the cycle after acceptance and busy never rises.
//   Other requests walk the list one link per cycle through the link RAM:
//     read at p        : walk to p, read the value RAM, answer
//     insert/push at p : walk to p - 1, link the new slot in (position 0: as new head)
//     remove/pop at p  : walk to p - 1, unlink and free the victim (position 0: no walk)
//   busy falls in the strobe cycle, so the next request may be taken there.
//   The result is not held: the receiver takes it in its strobe cycle.
//   After reset the list is empty and a request may be taken at once; freed slots
//   are reused first and fresh slots come from a fill counter, so no memory
//   clearing pass is needed.
`include "assert_macros.svh"

module positional_list_engine #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ple_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [ple_pkg::DATA_W-1:0]  req_value,
   input  logic [$clog2(CAPACITY+1)-1:0]      req_position,
   output logic                               rsp_strobe,
   output logic signed [ple_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_count,
   output logic [ple_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int SlotW = $clog2(CAPACITY);
   localparam int DataW = ple_pkg::DATA_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_WALK,
      S_VREAD,
      S_VDATA,
      S_INS_HEAD,
      S_INS_NEXT,
      S_INS_LINK,
      S_INS_PREV,
      S_REM_VIC,
      S_REM_VIC_D,
      S_REM_RD,
      S_REM_FIX,
      S_REM_FREE
   } state_type;

   state_type                    state_ff, state_in;
   logic [CntW-1:0]              count_ff, count_in;
   logic [CntW-1:0]              fill_ff, fill_in;
   logic [SlotW-1:0]             first_ff, first_in;
   logic [SlotW-1:0]             free_head_ff, free_head_in;
   logic [SlotW-1:0]             cur_ff, cur_in;
   logic [SlotW-1:0]             new_ff, new_in;
   logic [SlotW-1:0]             victim_ff, victim_in;
   logic [CntW-1:0]              left_ff, left_in;
   logic [CntW-1:0]              pos_ff, pos_in;
   logic                         pend_ff, pend_in;
   logic                         pzero_ff, pzero_in;
   logic                         take_free_ff, take_free_in;
   ple_pkg::op_type              op_ff, op_in;
   logic [VALUE_WIDTH-1:0]       value_ff, value_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic signed [DataW-1:0]      rsp_read_value_ff, rsp_read_value_in;
   logic [CntW-1:0]              rsp_count_ff, rsp_count_in;
   ple_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                         lnk_wr_en;
   logic [SlotW-1:0]             lnk_wr_addr;
   logic [SlotW-1:0]             lnk_wr_data;
   logic [SlotW-1:0]             lnk_rd_addr;
   logic [SlotW-1:0]             lnk_rd_data;
   logic                         val_wr_en;
   logic [VALUE_WIDTH-1:0]       val_rd_data;
   logic signed [VALUE_WIDTH-1:0] val_rd_s;
   logic                         recycled;

   assign recycled = (fill_ff != count_ff);
   assign val_rd_s = val_rd_data;

   always_comb begin
      logic [CntW-1:0]     p_sel;
      ple_pkg::status_type st;
      ple_pkg::op_type     op;
      logic [SlotW-1:0]    cur_sel;

      state_in          = state_ff;
      count_in          = count_ff;
      fill_in           = fill_ff;
      first_in          = first_ff;
      free_head_in      = free_head_ff;
      cur_in            = cur_ff;
      new_in            = new_ff;
      victim_in         = victim_ff;
      left_in           = left_ff;
      pos_in            = pos_ff;
      pend_in           = pend_ff;
      pzero_in          = pzero_ff;
      take_free_in      = take_free_ff;
      op_in             = op_ff;
      value_in          = value_ff;
      rsp_strobe_in     = 1'b0;
      rsp_read_value_in = '0;
      rsp_count_in      = rsp_count_ff;
      rsp_status_in     = rsp_status_ff;
      lnk_wr_en         = 1'b0;
      lnk_wr_addr       = cur_ff;
      lnk_wr_data       = new_ff;
      lnk_rd_addr       = free_head_ff;
      val_wr_en         = 1'b0;
      p_sel             = req_position;
      st                = ple_pkg::ST_OK;
      op                = ple_pkg::OP_READ;
      cur_sel           = pend_ff ? lnk_rd_data : cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (ple_pkg::action_type'(req_action))
                  ple_pkg::ACT_PUSH_FRONT: begin
                     p_sel = '0;
                     op    = ple_pkg::OP_INSERT;
                  end
                  ple_pkg::ACT_PUSH_BACK: begin
                     p_sel = count_ff;
                     op    = ple_pkg::OP_INSERT;
                  end
                  ple_pkg::ACT_INSERT: begin
                     op = ple_pkg::OP_INSERT;
                  end
                  ple_pkg::ACT_REMOVE_AT: begin
                     op = ple_pkg::OP_REMOVE;
                  end
                  ple_pkg::ACT_POP_FRONT: begin
                     p_sel = '0;
                     op    = ple_pkg::OP_REMOVE;
                  end
                  ple_pkg::ACT_POP_BACK: begin
                     p_sel = count_ff - CntW'(1);
                     op    = ple_pkg::OP_REMOVE;
                  end
                  ple_pkg::ACT_READ: begin
                     op = ple_pkg::OP_READ;
                  end
                  ple_pkg::ACT_CLEAR: begin
                     op = ple_pkg::OP_CLEAR;
                  end
                  default: begin
                     op = ple_pkg::OP_READ;
                  end
               endcase

               unique case (op)
                  ple_pkg::OP_INSERT: begin
                     if (count_ff == CntW'(CAPACITY)) begin
                        st = ple_pkg::ST_FULL;
                     end else if (p_sel > count_ff) begin
                        st = ple_pkg::ST_RANGE;
                     end
                  end
                  ple_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        st = ple_pkg::ST_EMPTY;
                     end else if (p_sel >= count_ff) begin
                        st = ple_pkg::ST_RANGE;
                     end
                  end
                  ple_pkg::OP_READ: begin
                     if (p_sel >= count_ff) begin
                        st = ple_pkg::ST_RANGE;
                     end
                  end
                  ple_pkg::OP_CLEAR: begin
                     st = ple_pkg::ST_OK;
                  end
                  default: begin
                     st = ple_pkg::ST_OK;
                  end
               endcase

               if (op == ple_pkg::OP_CLEAR || st != ple_pkg::ST_OK) begin
                  if (op == ple_pkg::OP_CLEAR) begin
                     count_in = '0;
                     fill_in  = '0;
                     first_in = '0;
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = st;
                  rsp_count_in  = (op == ple_pkg::OP_CLEAR) ? '0 : count_ff;
               end else begin
                  state_in     = S_SETUP;
                  op_in        = op;
                  pos_in       = p_sel;
                  pzero_in     = (p_sel == '0);
                  value_in     = VALUE_WIDTH'($unsigned(req_value));
                  take_free_in = 1'b0;
                  if (op == ple_pkg::OP_INSERT) begin
                     take_free_in = recycled;
                     if (recycled) begin
                        new_in = free_head_ff;
                     end else begin
                        new_in  = SlotW'(fill_ff);
                        fill_in = fill_ff + CntW'(1);
                     end
                  end
               end
            end
         end

         S_SETUP: begin
            if (take_free_ff) begin
               free_head_in = lnk_rd_data;
            end
            cur_in  = first_ff;
            pend_in = 1'b0;
            left_in = (op_ff == ple_pkg::OP_READ) ? pos_ff : pos_ff - CntW'(1);
            if (pzero_ff && op_ff == ple_pkg::OP_INSERT) begin
               state_in = S_INS_HEAD;
            end else if (pzero_ff && op_ff == ple_pkg::OP_REMOVE) begin
               victim_in = first_ff;
               state_in  = S_REM_RD;
            end else begin
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            if (left_ff == '0) begin
               cur_in  = cur_sel;
               pend_in = 1'b0;
               priority if (op_ff == ple_pkg::OP_READ) begin
                  state_in = S_VREAD;
               end else if (op_ff == ple_pkg::OP_INSERT) begin
                  state_in = S_INS_NEXT;
               end else begin
                  state_in = S_REM_VIC;
               end
            end else begin
               lnk_rd_addr = cur_sel;
               left_in     = left_ff - CntW'(1);
               pend_in     = 1'b1;
            end
         end

         S_VREAD: begin
            state_in = S_VDATA;
         end

         S_VDATA: begin
            rsp_strobe_in     = 1'b1;
            rsp_status_in     = ple_pkg::ST_OK;
            rsp_count_in      = count_ff;
            rsp_read_value_in = DataW'(val_rd_s);
            state_in          = S_IDLE;
         end

         S_INS_HEAD: begin
            lnk_wr_en     = 1'b1;
            lnk_wr_addr   = new_ff;
            lnk_wr_data   = first_ff;
            val_wr_en     = 1'b1;
            first_in      = new_ff;
            count_in      = count_ff + CntW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ple_pkg::ST_OK;
            rsp_count_in  = count_ff + CntW'(1);
            state_in      = S_IDLE;
         end

         S_INS_NEXT: begin
            lnk_rd_addr = cur_ff;
            state_in    = S_INS_LINK;
         end

         S_INS_LINK: begin
            lnk_wr_en   = 1'b1;
            lnk_wr_addr = new_ff;
            lnk_wr_data = lnk_rd_data;
            val_wr_en   = 1'b1;
            state_in    = S_INS_PREV;
         end

         S_INS_PREV: begin
            lnk_wr_en     = 1'b1;
            lnk_wr_addr   = cur_ff;
            lnk_wr_data   = new_ff;
            count_in      = count_ff + CntW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ple_pkg::ST_OK;
            rsp_count_in  = count_ff + CntW'(1);
            state_in      = S_IDLE;
         end

         S_REM_VIC: begin
            lnk_rd_addr = cur_ff;
            state_in    = S_REM_VIC_D;
         end

         S_REM_VIC_D: begin
            victim_in = lnk_rd_data;
            state_in  = S_REM_RD;
         end

         S_REM_RD: begin
            lnk_rd_addr = victim_ff;
            state_in    = S_REM_FIX;
         end

         S_REM_FIX: begin
            if (pzero_ff) begin
               first_in = lnk_rd_data;
            end else begin
               lnk_wr_en   = 1'b1;
               lnk_wr_addr = cur_ff;
               lnk_wr_data = lnk_rd_data;
            end
            state_in = S_REM_FREE;
         end

         S_REM_FREE: begin
            lnk_wr_en     = 1'b1;
            lnk_wr_addr   = victim_ff;
            lnk_wr_data   = free_head_ff;
            free_head_in  = victim_ff;
            count_in      = count_ff - CntW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ple_pkg::ST_OK;
            rsp_count_in  = count_ff - CntW'(1);
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         fill_ff       <= '0;
         first_ff      <= '0;
         free_head_ff  <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fill_ff       <= fill_in;
         first_ff      <= first_in;
         free_head_ff  <= free_head_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_ff            <= cur_in;
      new_ff            <= new_in;
      victim_ff         <= victim_in;
      left_ff           <= left_in;
      pos_ff            <= pos_in;
      pzero_ff          <= pzero_in;
      take_free_ff      <= take_free_in;
      op_ff             <= op_in;
      value_ff          <= value_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

   ple_ram #(
      .WIDTH (SlotW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_wr_en),
      .wr_addr (lnk_wr_addr),
      .wr_data (lnk_wr_data),
      .rd_addr (lnk_rd_addr),
      .rd_data (lnk_rd_data)
   );

   ple_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (new_ff),
      .wr_data (value_ff),
      .rd_addr (cur_ff),
      .rd_data (val_rd_data)
   );

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   `ASSERT_ALWAYS(a_count_cap, count_ff <= CntW'(CAPACITY), "entry count above capacity")
   `ASSERT_ALWAYS(a_fill_ge_count, fill_ff >= count_ff, "more entries than slots handed out")
   `ASSERT_IMPL(a_walk_bound, state_ff == S_WALK, left_ff < count_ff, "walk runs past list end")
   `ASSERT_NEXT(a_no_stray_rsp, (state_ff == S_IDLE) && !start, !rsp_strobe_ff, "result without request")

endmodule
